// ===== rtl/core/hhw_pkg.sv =====
`default_nettype none
package hhw_pkg;

  // fixed widths of the data path
  localparam int SampleBits = 16;
  localparam int CoefBits   = 16;
  localparam int LenBits    = 11;
  localparam int PosBits    = 10;
  localparam int MaxWindow  = 1024;

  // configuration register indexes
  localparam logic [1:0] RegShape  = 2'd0;
  localparam logic [1:0] RegLength = 2'd1;

  // reset length of a frame
  localparam logic [LenBits-1:0] LenReset = 11'd256;

  // hamming constants in q1.15
  localparam logic [15:0] HamA = 16'd17695;
  localparam logic [15:0] HamB = 16'd15073;

  // cosine polynomial constants in q30
  localparam logic [30:0] CosC1 = 31'd1324675879;
  localparam logic [30:0] CosC2 = 31'd272375560;
  localparam logic [30:0] CosC3 = 31'd22401995;
  localparam logic [30:0] CosC4 = 31'd987048;
  localparam logic [30:0] Q30One = 31'h4000_0000;

  // horner step constant: step 0 uses c3, then c2, c1 and finally one
  function automatic logic [30:0] horner_const(input logic [1:0] step);
    logic [30:0] v;
    case (step)
      2'd0:    v = CosC3;
      2'd1:    v = CosC2;
      2'd2:    v = CosC1;
      default: v = Q30One;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hann_hamming_windowing_unit.sv =====
`default_nettype none
// Hann or Hamming windowing of a sample stream. Each input beat carries one
// signed 16-bit sample; it is multiplied by the coefficient for its place k
// (1..N) in the frame, the coefficient being worked out on the fly as
// 0.5-0.5cos(2pi k/(N+1)) or 0.54-0.46cos(2pi k/(N+1)) in unsigned q1.15,
// and the product is rounded and saturated to 16 bits. The result beat marks
// the last sample of each frame. Configuration writes (index 0 shape,
// index 1 length) apply from the next accepted sample; a length of 0 acts as
// 1 and one above 1024 acts as 1024. After a sample is accepted, a
// bit-serial restoring divider produces the phase, then one shared shift-add
// multiplier, one bit a cycle, runs five times (square of the phase and four
// polynomial steps), and the coefficient state forms the coefficient and the
// output state the product, once the output register is free. No new sample
// is taken until the last one has reached the output register. The result
// sits in an output register, so a new sample is taken while it waits.
module hann_hamming_windowing_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [hhw_pkg::SampleBits-1:0] in_sample,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic signed [hhw_pkg::SampleBits-1:0] out_windowed_sample,
  output logic                            out_last_of_frame,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [1:0]                      cfg_index,
  input  wire  [hhw_pkg::LenBits-1:0]     cfg_data
);
  import hhw_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SQR  = 6'b000100,
    ST_HORN = 6'b001000,
    ST_COEF = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic               shape_cfg_r;
  logic [LenBits-1:0] len_cfg_r;
  logic [PosBits-1:0] pos_r, pos_nxt;

  logic signed [SampleBits-1:0] x_r, x_nxt;
  logic               shape_r, shape_nxt;
  logic               last_r, last_nxt;
  logic [LenBits-1:0] d_r, d_nxt;
  logic [11:0]        rem_r, rem_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               neg_r, neg_nxt;
  logic [30:0]        y_r, y_nxt;
  logic [30:0]        c_r, c_nxt;
  logic [1:0]         hstep_r, hstep_nxt;
  logic [30:0]        mul_a_r, mul_a_nxt;
  logic [31:0]        mul_hi_r, mul_hi_nxt;
  logic [30:0]        mul_lo_r, mul_lo_nxt;
  logic [CoefBits-1:0] coef_r, coef_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [SampleBits-1:0] out_sample_r, out_sample_nxt;
  logic               out_last_r, out_last_nxt;

  // frame bookkeeping at acceptance
  logic [LenBits-1:0] len_eff, k_inc, k_cl, np1, m_val;
  logic               is_last;
  // divider step
  logic [11:0]        div_t;
  logic               div_ge;
  logic [31:0]        p_fin;
  logic               p_neg;
  logic [31:0]        u_wide;
  // multiplier step
  logic [31:0]        mul_sum;
  logic [31:0]        step_hi;
  logic [30:0]        step_lo;
  logic [30:0]        prod_sh;
  logic [31:0]        horn_diff;
  // coefficient and product
  logic [30:0]        c_rnd;
  logic [15:0]        q_val;
  logic [16:0]        hann_sum;
  logic [29:0]        ham_prod;
  logic [15:0]        ham_t;
  logic signed [32:0] prod_full;
  logic signed [17:0] prod_shift;
  logic signed [SampleBits-1:0] prod_sat;
  logic               accept, out_free;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_windowed_sample = out_sample_r;
  assign out_last_of_frame   = out_last_r;

  // effective length and frame position
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = 11'd1;
    end else if (len_cfg_r > LenBits'(MaxWindow)) begin
      len_eff = LenBits'(MaxWindow);
    end else begin
      len_eff = len_cfg_r;
    end
    k_inc   = {1'b0, pos_r} + 11'd1;
    is_last = (k_inc >= len_eff);
    k_cl    = (k_inc > len_eff) ? len_eff : k_inc;
    np1     = len_eff + 11'd1;
    m_val   = ({k_cl, 1'b0} > {1'b0, np1}) ? (np1 - k_cl) : k_cl;
  end

  // divider, multiplier and coefficient datapath
  always_comb begin
    div_t  = {rem_r[10:0], 1'b0};
    div_ge = (div_t >= {1'b0, d_r});
    p_fin  = {quo_r[30:0], div_ge};
    p_neg  = (p_fin > 32'h4000_0000);
    u_wide = p_neg ? (32'h8000_0000 - p_fin) : p_fin;

    mul_sum   = mul_hi_r + (mul_lo_r[0] ? {1'b0, mul_a_r} : 32'd0);
    step_hi   = {1'b0, mul_sum[31:1]};
    step_lo   = {mul_sum[0], mul_lo_r[30:1]};
    prod_sh   = {step_hi[29:0], step_lo[30]};
    horn_diff = {1'b0, horner_const(hstep_r)} - {1'b0, prod_sh};

    c_rnd    = c_r + 31'd16384;
    q_val    = c_rnd[30:15];
    hann_sum = neg_r ? (17'd32769 + {1'b0, q_val}) : (17'd32769 - {1'b0, q_val});
    ham_prod = 30'(HamB) * 30'(q_val) + 30'd16384;
    ham_t    = {1'b0, ham_prod[29:15]};

    prod_full  = x_r * $signed({1'b0, coef_r}) + 33'sd16384;
    prod_shift = 18'(prod_full >>> 15);
    if (prod_shift > 18'sd32767) begin
      prod_sat = 16'sh7fff;
    end else if (prod_shift < -18'sd32768) begin
      prod_sat = -16'sh8000;
    end else begin
      prod_sat = prod_shift[15:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    x_nxt          = x_r;
    shape_nxt      = shape_r;
    last_nxt       = last_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    y_nxt          = y_r;
    c_nxt          = c_r;
    hstep_nxt      = hstep_r;
    mul_a_nxt      = mul_a_r;
    mul_hi_nxt     = mul_hi_r;
    mul_lo_nxt     = mul_lo_r;
    coef_nxt       = coef_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          x_nxt     = in_sample;
          shape_nxt = shape_cfg_r;
          last_nxt  = is_last;
          pos_nxt   = is_last ? '0 : k_inc[PosBits-1:0];
          d_nxt     = np1;
          rem_nxt   = {1'b0, m_val};
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? (div_t - {1'b0, d_r}) : div_t;
        quo_nxt = p_fin;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          neg_nxt    = p_neg;
          mul_a_nxt  = u_wide[30:0];
          mul_lo_nxt = u_wide[30:0];
          mul_hi_nxt = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_SQR;
        end
      end
      ST_SQR: begin
        mul_hi_nxt = step_hi;
        mul_lo_nxt = step_lo;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          y_nxt      = prod_sh;
          mul_a_nxt  = CosC4;
          mul_lo_nxt = prod_sh;
          mul_hi_nxt = '0;
          hstep_nxt  = '0;
          cnt_nxt    = '0;
          state_nxt  = ST_HORN;
        end
      end
      ST_HORN: begin
        mul_hi_nxt = step_hi;
        mul_lo_nxt = step_lo;
        cnt_nxt    = cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          cnt_nxt = '0;
          if (hstep_r == 2'd3) begin
            // cosine in q30, clamped at zero
            c_nxt     = horn_diff[31] ? '0 : horn_diff[30:0];
            state_nxt = ST_COEF;
          end else begin
            mul_a_nxt  = horn_diff[31] ? '0 : horn_diff[30:0];
            mul_lo_nxt = y_r;
            mul_hi_nxt = '0;
            hstep_nxt  = hstep_r + 2'd1;
          end
        end
      end
      ST_COEF: begin
        if (shape_r) begin
          coef_nxt = neg_r ? (HamA + ham_t) : (HamA - ham_t);
        end else begin
          coef_nxt = hann_sum[16:1];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = prod_sat;
          out_last_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      coef_r      <= '0;
      shape_cfg_r <= 1'b0;
      len_cfg_r   <= LenReset;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      coef_r      <= coef_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegShape) begin
          shape_cfg_r <= cfg_data[0];
        end else if (cfg_index == RegLength) begin
          len_cfg_r <= cfg_data;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    shape_r      <= shape_nxt;
    last_r       <= last_nxt;
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    cnt_r        <= cnt_nxt;
    neg_r        <= neg_nxt;
    y_r          <= y_nxt;
    c_r          <= c_nxt;
    hstep_r      <= hstep_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_hi_r     <= mul_hi_nxt;
    mul_lo_r     <= mul_lo_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/hhw_checker.sv =====
`default_nettype none
module hhw_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [hhw_pkg::SampleBits-1:0]    out_windowed_sample,
  input wire                              out_last_of_frame
);
  import hhw_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_windowed_sample) && $stable(out_last_of_frame))
    else $error("result payload changed while stalled");

  // once a sample is taken the block is busy with it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample taken while one is in work");

  // reset leaves the block empty and ready
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind hann_hamming_windowing_unit hhw_checker u_hhw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_windowed_sample (out_windowed_sample),
  .out_last_of_frame   (out_last_of_frame)
);
`default_nettype wire
